// ===== rtl/core/shortest_path_engine_top_macros.svh =====
// assertion macros for the shortest path engine
`ifndef SHORTEST_PATH_ENGINE_TOP_MACROS_SVH
`define SHORTEST_PATH_ENGINE_TOP_MACROS_SVH

// same-cycle implication, clk and rst_n taken from the using scope
`define SPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spe assertion failed");

// next-cycle implication
`define SPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spe assertion failed");

`endif

// ===== rtl/core/spe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_pkg
// shared types and constants of the shortest path engine
// ----------------------------------------------------------------------------
package spe_pkg;

  localparam int DIST_BITS  = 22;
  localparam int IDX_BITS   = 10;
  localparam int CMP_BITS   = 11;
  localparam int CFG_BITS   = 7;
  localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] DIST_TOP = DIST_INF - 1'b1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  node_a;
    logic [5:0]  node_b;
    logic [15:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 unreachable;
  } out_item_t;

  typedef struct packed {
    logic                 valid;
    logic [DIST_BITS-1:0] cost;
    logic [IDX_BITS-1:0]  idx;
  } scan_t;

  typedef struct packed {
    logic                 init;
    logic                 settle;
    logic                 relax;
    logic [IDX_BITS-1:0]  node;
    logic [DIST_BITS-1:0] cand;
  } cell_cmd_t;

endpackage

// ===== rtl/core/spe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_if
// valid/ready channels carrying input and result items
// ----------------------------------------------------------------------------
interface spe_in_if;
  logic              valid;
  logic              ready;
  spe_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spe_out_if;
  logic               valid;
  logic               ready;
  spe_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/spe_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_cell
// one node: tentative distance, settled flag and one stage of the min scan
// ----------------------------------------------------------------------------
module spe_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               active,
  input  spe_pkg::cell_cmd_t cmd,
  input  spe_pkg::scan_t     scan_in,
  output spe_pkg::scan_t     scan_out
);
  import spe_pkg::*;

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(IDX);

  logic [DIST_BITS-1:0] dist_r, dist_nxt;
  logic                 settled_r, settled_nxt;
  scan_t                scan_r, scan_nxt;
  logic                 eligible;
  logic                 hit;

  assign hit      = (cmd.node == MY_IDX);
  assign eligible = active && !settled_r && (dist_r != DIST_INF);

  always_comb begin
    if (eligible && (!scan_in.valid || dist_r < scan_in.cost)) begin
      scan_nxt = '{valid: 1'b1, cost: dist_r, idx: MY_IDX};
    end else begin
      scan_nxt = scan_in;
    end
  end

  always_comb begin
    dist_nxt    = dist_r;
    settled_nxt = settled_r;
    priority if (cmd.init) begin
      dist_nxt    = (IDX == 0) ? '0 : DIST_INF;
      settled_nxt = 1'b0;
    end else if (cmd.settle && hit) begin
      settled_nxt = 1'b1;
    end else if (cmd.relax && hit && !settled_r && (cmd.cand < dist_r)) begin
      dist_nxt = cmd.cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r    <= DIST_INF;
      settled_r <= 1'b0;
      scan_r    <= '0;
    end else begin
      dist_r    <= dist_nxt;
      settled_r <= settled_nxt;
      scan_r    <= scan_nxt;
    end
  end

  assign scan_out = scan_r;

endmodule

// ===== rtl/core/spe_cell_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_cell_row
// chain of node cells; the min token ripples one cell per cycle
// ----------------------------------------------------------------------------
module spe_cell_row #(
  parameter int MAX_NODES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [$clog2(MAX_NODES+1)-1:0]   n_use,
  input  spe_pkg::cell_cmd_t               cmd,
  output spe_pkg::scan_t                   scan_last
);
  import spe_pkg::*;

  localparam int CW = $clog2(MAX_NODES+1);

  scan_t chain [MAX_NODES+1];

  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    spe_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .active   (n_use > CW'(i)),
      .cmd      (cmd),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

  assign scan_last = chain[MAX_NODES];

endmodule

// ===== rtl/core/shortest_path_engine_top.sv =====
`timescale 1ns / 1ps
// a query runs min scans through the cell row, with a relax round over the edge store
//   between two scans; one scan ripples through all MAX_NODES cells
// load, clear and unused items are done in the idle state; one item is in work at a time and the next
//   is taken the cycle after the result is registered, later while the output stays full
// reset (synchronous, rst_n low) empties the edge store and sets node_count to 64
// ----------------------------------------------------------------------------
// shortest_path_engine_top
// dijkstra from node 0 to the last node over a stored undirected edge list
// ----------------------------------------------------------------------------
module shortest_path_engine_top #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_EDGES   = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [spe_pkg::CFG_BITS-1:0] cfg_wdata,
  spe_in_if.sink                       in_ch,
  spe_out_if.source                    out_ch
);
  import spe_pkg::*;

  `include "shortest_path_engine_top_macros.svh"

  localparam int CW = $clog2(MAX_NODES+1);
  localparam int NW = $clog2(MAX_NODES);
  localparam int KW = (CW > CFG_BITS) ? CW : CFG_BITS;
  localparam int TW = $clog2(MAX_EDGES+1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int SW = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INIT  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_PICK  = 6'b001000,
    S_RELAX = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CFG_BITS-1:0]   node_count_r;
  logic [TW-1:0]         total_r, total_nxt;
  logic [NW-1:0]         scan_cnt_r, scan_cnt_nxt;
  logic [TW-1:0]         edge_cnt_r, edge_cnt_nxt;
  logic                  q_valid_r, q_valid_nxt;
  logic [IDX_BITS-1:0]   best_r, best_nxt;
  logic [DIST_BITS-1:0]  best_dist_r, best_dist_nxt;
  out_item_t             res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [5:0]            mem_a   [MAX_EDGES];
  logic [5:0]            mem_b   [MAX_EDGES];
  logic [WEIGHT_BITS-1:0] mem_len [MAX_EDGES];
  logic [5:0]            q_a_r, q_b_r;
  logic [WEIGHT_BITS-1:0] q_len_r;

  logic [CW-1:0]         n_use;
  logic [CMP_BITS-1:0]   n_cmp, target_cmp, a_cmp, b_cmp, best_cmp;
  logic                  in_fire, mem_we, mem_re;
  logic [SW-1:0]         sum;
  logic [DIST_BITS-1:0]  cand;
  logic                  ends_ok;
  cell_cmd_t             cmd;
  scan_t                 tok;
  in_item_t              item;

  assign item    = in_ch.data;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;

  // node count clamped into 2..MAX_NODES
  always_comb begin
    if (node_count_r < CFG_BITS'(2)) begin
      n_use = CW'(2);
    end else if (KW'(node_count_r) > KW'(MAX_NODES)) begin
      n_use = CW'(MAX_NODES);
    end else begin
      n_use = CW'(node_count_r);
    end
  end

  assign n_cmp      = CMP_BITS'(n_use);
  assign target_cmp = n_cmp - 1'b1;
  assign a_cmp      = CMP_BITS'(q_a_r);
  assign b_cmp      = CMP_BITS'(q_b_r);
  assign best_cmp   = CMP_BITS'(best_r);
  assign ends_ok    = (a_cmp < n_cmp) && (b_cmp < n_cmp);

  assign sum  = SW'(best_dist_r) + SW'(q_len_r);
  assign cand = (sum > SW'(DIST_TOP)) ? DIST_TOP : sum[DIST_BITS-1:0];

  // edge store
  assign mem_we = in_fire && (item.mode == MODE_LOAD) && (total_r < TW'(MAX_EDGES));
  assign mem_re = (state_r == S_RELAX) && (edge_cnt_r < total_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_a[total_r[AW-1:0]]   <= item.node_a;
      mem_b[total_r[AW-1:0]]   <= item.node_b;
      mem_len[total_r[AW-1:0]] <= WEIGHT_BITS'(item.weight);
    end
    if (mem_re) begin
      q_a_r   <= mem_a[edge_cnt_r[AW-1:0]];
      q_b_r   <= mem_b[edge_cnt_r[AW-1:0]];
      q_len_r <= mem_len[edge_cnt_r[AW-1:0]];
    end
  end

  // command broadcast to the cells
  always_comb begin
    cmd        = '0;
    cmd.init   = (state_r == S_INIT);
    cmd.settle = (state_r == S_PICK) && tok.valid;
    cmd.cand   = cand;
    if (state_r == S_PICK) begin
      cmd.node = tok.idx;
    end else if (a_cmp == best_cmp) begin
      cmd.node  = IDX_BITS'(q_b_r);
      cmd.relax = q_valid_r && ends_ok;
    end else begin
      cmd.node  = IDX_BITS'(q_a_r);
      cmd.relax = q_valid_r && ends_ok && (b_cmp == best_cmp);
    end
  end

  spe_cell_row #(.MAX_NODES(MAX_NODES)) u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_use     (n_use),
    .cmd       (cmd),
    .scan_last (tok)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    scan_cnt_nxt  = scan_cnt_r;
    edge_cnt_nxt  = edge_cnt_r;
    q_valid_nxt   = mem_re;
    best_nxt      = best_r;
    best_dist_nxt = best_dist_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (item.mode)
            MODE_LOAD:  if (mem_we) total_nxt = total_r + 1'b1;
            MODE_CLEAR: total_nxt = '0;
            MODE_QUERY: state_nxt = S_INIT;
            default:    ;
          endcase
        end
      end
      S_INIT: begin
        scan_cnt_nxt = '0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == NW'(MAX_NODES-1)) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        best_nxt      = tok.idx;
        best_dist_nxt = tok.cost;
        edge_cnt_nxt  = '0;
        priority if (!tok.valid) begin
          res_nxt   = '{distance: '0, unreachable: 1'b1};
          state_nxt = S_DONE;
        end else if (CMP_BITS'(tok.idx) == target_cmp) begin
          res_nxt   = '{distance: tok.cost, unreachable: 1'b0};
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RELAX;
        end
      end
      S_RELAX: begin
        if (mem_re) begin
          edge_cnt_nxt = edge_cnt_r + 1'b1;
        end else if (!q_valid_r) begin
          scan_cnt_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= CFG_BITS'(64);
      total_r      <= '0;
      scan_cnt_r   <= '0;
      edge_cnt_r   <= '0;
      q_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      total_r    <= total_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      q_valid_r  <= q_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    best_dist_r <= best_dist_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `SPE_ASSERT_IMP(a_relax_in_relax, cmd.relax, state_r == S_RELAX)
  `SPE_ASSERT_IMP(a_total_bound, 1'b1, total_r <= TW'(MAX_EDGES))
  `SPE_ASSERT_IMP(a_out_from_done, $rose(out_valid_r), $past(state_r) == S_DONE)
  `SPE_ASSERT_NXT(a_pick_leaves, state_r == S_PICK, state_r == S_RELAX || state_r == S_DONE)

endmodule
